FILE: hdl/rpa_pkg.sv
package rpa_pkg;

    // Fixed-point widths of the datapath
    localparam int COORD_W   = 32;  // Q16.16 coordinate
    localparam int COEF_W    = 16;  // Q2.14 axis, cosine, sine
    localparam int DIFF_W    = 33;  // point minus center
    localparam int PROD_W    = 49;  // coefficient times difference
    localparam int DSUM_W    = 51;  // sum of three products
    localparam int DOT_W     = 37;  // rounded dot product
    localparam int CDIFF_W   = 50;  // difference of two products
    localparam int CROSS_W   = 36;  // rounded cross product term
    localparam int OM_W      = 17;  // one minus cosine
    localparam int WPROD_W   = 54;  // dot times (one minus cosine)
    localparam int W_W       = 40;  // rounded projection weight
    localparam int XS_W      = 52;  // cross term times sine
    localparam int KW_W      = 56;  // axis times weight
    localparam int ACC_W     = 58;  // full accumulator
    localparam int RND_W     = 44;  // rounded accumulator
    localparam int SUM_W     = 45;  // rounded accumulator plus center

    localparam int FRAC_BITS = 14;
    localparam int RND_HALF  = 8192;
    localparam int ONE_Q14   = 16384;

    // Register reset values
    localparam int AXIS_Z_RESET = 16384;
    localparam int COS_RESET    = 16384;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_COS      = 3'd6,
        REG_SIN      = 3'd7
    } reg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DSUM_W-1:0]  dsum_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [CDIFF_W-1:0] cdiff_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [OM_W-1:0]    om_t;
    typedef logic signed [WPROD_W-1:0] wprod_t;
    typedef logic signed [W_W-1:0]     w_t;
    typedef logic signed [XS_W-1:0]    xs_t;
    typedef logic signed [KW_W-1:0]    kw_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RND_W-1:0]   rnd_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // Item marker that travels with the data
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    // Configuration seen by the datapath
    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        coef_t  axis_x;
        coef_t  axis_y;
        coef_t  axis_z;
        coef_t  cos_angle;
        coef_t  sin_angle;
    } cfg_t;

endpackage

FILE: hdl/rpa_proj.sv
module rpa_proj (
    input  logic            clk,
    input  logic            rst_n,
    input  rpa_pkg::ctl_t   in_ctl,
    input  rpa_pkg::coord_t point_x,
    input  rpa_pkg::coord_t point_y,
    input  rpa_pkg::coord_t point_z,
    input  rpa_pkg::cfg_t   cfg,
    output rpa_pkg::ctl_t   out_ctl,
    output rpa_pkg::diff_t  diff [3],
    output rpa_pkg::dot_t   dot,
    output rpa_pkg::cross_t xprod [3]
);

    rpa_pkg::coord_t pt [3];
    rpa_pkg::coord_t cen [3];
    rpa_pkg::coef_t  k [3];

    rpa_pkg::ctl_t   ctl1_reg, ctl2_reg, ctl3_reg;
    rpa_pkg::diff_t  d1_next [3];
    rpa_pkg::diff_t  d1_reg [3];
    rpa_pkg::diff_t  d2_reg [3];
    rpa_pkg::diff_t  d3_reg [3];
    rpa_pkg::prod_t  sq2_reg [3];
    rpa_pkg::prod_t  pa2_reg [3];
    rpa_pkg::prod_t  pb2_reg [3];
    rpa_pkg::dot_t   dot3_next;
    rpa_pkg::dot_t   dot3_reg;
    rpa_pkg::cross_t x3_next [3];
    rpa_pkg::cross_t x3_reg [3];

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign cen[0] = cfg.center_x;
    assign cen[1] = cfg.center_y;
    assign cen[2] = cfg.center_z;
    assign k[0]   = cfg.axis_x;
    assign k[1]   = cfg.axis_y;
    assign k[2]   = cfg.axis_z;

    // Offset from the rotation center
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = rpa_pkg::diff_t'(pt[i]) - rpa_pkg::diff_t'(cen[i]);
        end
    end

    // Dot sum and cross differences, rounded to Q16.16
    always_comb
    begin
        rpa_pkg::dsum_t  dsum;
        rpa_pkg::dsum_t  dshift;
        rpa_pkg::cdiff_t cd;
        rpa_pkg::cdiff_t cshift;
        dsum = rpa_pkg::dsum_t'(sq2_reg[0]) + rpa_pkg::dsum_t'(sq2_reg[1])
             + rpa_pkg::dsum_t'(sq2_reg[2]) + rpa_pkg::dsum_t'(rpa_pkg::RND_HALF);
        dshift = dsum >>> rpa_pkg::FRAC_BITS;
        dot3_next = dshift[rpa_pkg::DOT_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            cd = rpa_pkg::cdiff_t'(pa2_reg[i]) - rpa_pkg::cdiff_t'(pb2_reg[i])
               + rpa_pkg::cdiff_t'(rpa_pkg::RND_HALF);
            cshift = cd >>> rpa_pkg::FRAC_BITS;
            x3_next[i] = cshift[rpa_pkg::CROSS_W-1:0];
        end
    end

    // Advance the control markers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Payload stages: offset, products, dot and cross
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i]  <= d1_next[i];
            d2_reg[i]  <= d1_reg[i];
            d3_reg[i]  <= d2_reg[i];
            sq2_reg[i] <= rpa_pkg::prod_t'(k[i]) * rpa_pkg::prod_t'(d1_reg[i]);
            x3_reg[i]  <= x3_next[i];
        end
        // cyclic cross product terms: x_i = k_j*d_m - k_m*d_j
        pa2_reg[0] <= rpa_pkg::prod_t'(k[1]) * rpa_pkg::prod_t'(d1_reg[2]);
        pb2_reg[0] <= rpa_pkg::prod_t'(k[2]) * rpa_pkg::prod_t'(d1_reg[1]);
        pa2_reg[1] <= rpa_pkg::prod_t'(k[2]) * rpa_pkg::prod_t'(d1_reg[0]);
        pb2_reg[1] <= rpa_pkg::prod_t'(k[0]) * rpa_pkg::prod_t'(d1_reg[2]);
        pa2_reg[2] <= rpa_pkg::prod_t'(k[0]) * rpa_pkg::prod_t'(d1_reg[1]);
        pb2_reg[2] <= rpa_pkg::prod_t'(k[1]) * rpa_pkg::prod_t'(d1_reg[0]);
        dot3_reg   <= dot3_next;
    end

    assign out_ctl = ctl3_reg;
    assign dot     = dot3_reg;
    assign diff    = d3_reg;
    assign xprod   = x3_reg;

endmodule

FILE: hdl/rpa_combine.sv
module rpa_combine (
    input  logic            clk,
    input  logic            rst_n,
    input  rpa_pkg::ctl_t   in_ctl,
    input  rpa_pkg::diff_t  diff [3],
    input  rpa_pkg::dot_t   dot,
    input  rpa_pkg::cross_t xprod [3],
    input  rpa_pkg::cfg_t   cfg,
    output rpa_pkg::ctl_t   out_ctl,
    output rpa_pkg::acc_t   acc [3]
);

    rpa_pkg::coef_t  k [3];
    rpa_pkg::coef_t  cos_q;
    rpa_pkg::coef_t  sin_q;
    rpa_pkg::om_t    om;

    rpa_pkg::ctl_t   ctl4_reg, ctl5_reg, ctl6_reg, ctl7_reg;
    rpa_pkg::wprod_t wp4_reg;
    rpa_pkg::prod_t  dc4_reg [3];
    rpa_pkg::xs_t    xs4_reg [3];
    rpa_pkg::w_t     w5_next;
    rpa_pkg::w_t     w5_reg;
    rpa_pkg::acc_t   part5_reg [3];
    rpa_pkg::acc_t   part6_reg [3];
    rpa_pkg::kw_t    kw6_reg [3];
    rpa_pkg::acc_t   acc7_reg [3];

    assign k[0]  = cfg.axis_x;
    assign k[1]  = cfg.axis_y;
    assign k[2]  = cfg.axis_z;
    assign cos_q = cfg.cos_angle;
    assign sin_q = cfg.sin_angle;

    // One minus cosine, Q3.14
    assign om = rpa_pkg::om_t'(rpa_pkg::ONE_Q14) - rpa_pkg::om_t'(cos_q);

    // Round the projection weight to Q16.16
    always_comb
    begin
        rpa_pkg::wprod_t wsum;
        rpa_pkg::wprod_t wshift;
        wsum    = wp4_reg + rpa_pkg::wprod_t'(rpa_pkg::RND_HALF);
        wshift  = wsum >>> rpa_pkg::FRAC_BITS;
        w5_next = wshift[rpa_pkg::W_W-1:0];
    end

    // Advance the control markers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end
        else
        begin
            ctl4_reg <= in_ctl;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    // Payload stages: products, weight, axis term, accumulate
    always_ff @(posedge clk)
    begin
        wp4_reg <= rpa_pkg::wprod_t'(dot) * rpa_pkg::wprod_t'(om);
        w5_reg  <= w5_next;
        for (int i = 0; i < 3; i++)
        begin
            dc4_reg[i]   <= rpa_pkg::prod_t'(diff[i]) * rpa_pkg::prod_t'(cos_q);
            xs4_reg[i]   <= rpa_pkg::xs_t'(xprod[i]) * rpa_pkg::xs_t'(sin_q);
            part5_reg[i] <= rpa_pkg::acc_t'(dc4_reg[i]) + rpa_pkg::acc_t'(xs4_reg[i]);
            part6_reg[i] <= part5_reg[i];
            kw6_reg[i]   <= rpa_pkg::kw_t'(k[i]) * rpa_pkg::kw_t'(w5_reg);
            acc7_reg[i]  <= rpa_pkg::acc_t'(kw6_reg[i]) + part6_reg[i];
        end
    end

    assign out_ctl = ctl7_reg;
    assign acc     = acc7_reg;

endmodule

FILE: hdl/rpa_out.sv
module rpa_out (
    input  logic            clk,
    input  logic            rst_n,
    input  rpa_pkg::ctl_t   in_ctl,
    input  rpa_pkg::acc_t   acc [3],
    input  rpa_pkg::cfg_t   cfg,
    output logic            done,
    output rpa_pkg::coord_t rotated_x,
    output rpa_pkg::coord_t rotated_y,
    output rpa_pkg::coord_t rotated_z,
    output logic            overflow,
    output logic            last_out
);

    localparam rpa_pkg::coord_t COORD_MAX = {1'b0, {(rpa_pkg::COORD_W-1){1'b1}}};
    localparam rpa_pkg::coord_t COORD_MIN = {1'b1, {(rpa_pkg::COORD_W-1){1'b0}}};

    rpa_pkg::coord_t cen [3];
    rpa_pkg::coord_t res_next [3];
    logic [2:0]      sat_next;

    logic            done_reg;
    logic            last_reg;
    logic            ovf_reg;
    rpa_pkg::coord_t res_reg [3];

    assign cen[0] = cfg.center_x;
    assign cen[1] = cfg.center_y;
    assign cen[2] = cfg.center_z;

    // Round, add the center back, clamp to 32 bits
    always_comb
    begin
        rpa_pkg::acc_t asum;
        rpa_pkg::acc_t ashift;
        rpa_pkg::rnd_t rnd;
        rpa_pkg::sum_t sum;
        for (int i = 0; i < 3; i++)
        begin
            asum   = acc[i] + rpa_pkg::acc_t'(rpa_pkg::RND_HALF);
            ashift = asum >>> rpa_pkg::FRAC_BITS;
            rnd    = ashift[rpa_pkg::RND_W-1:0];
            sum    = rpa_pkg::sum_t'(rnd) + rpa_pkg::sum_t'(cen[i]);
            if (sum > rpa_pkg::sum_t'(COORD_MAX))
            begin
                res_next[i] = COORD_MAX;
                sat_next[i] = 1'b1;
            end
            else if (sum < rpa_pkg::sum_t'(COORD_MIN))
            begin
                res_next[i] = COORD_MIN;
                sat_next[i] = 1'b1;
            end
            else
            begin
                res_next[i] = sum[rpa_pkg::COORD_W-1:0];
                sat_next[i] = 1'b0;
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_ctl.valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_reg[i] <= res_next[i];
        end
        ovf_reg  <= |sat_next;
        last_reg <= in_ctl.last;
    end

    assign done      = done_reg;
    assign rotated_x = res_reg[0];
    assign rotated_y = res_reg[1];
    assign rotated_z = res_reg[2];
    assign overflow  = ovf_reg;
    assign last_out  = last_reg;

endmodule

FILE: hdl/point_rotate_about_axis_top.sv
// Rotates Q16.16 points about a configured axis through a configured center.
// Items pass the registers of rpa_proj, rpa_combine and rpa_out, in that order, before done is high.
// Throughput: one item per cycle, set by the eight-stage multiply pipeline.
// busy stays low; the receiver cannot stall, so results stream out one per cycle.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the registers.
module point_rotate_about_axis_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_z,
    input  logic        last_in,
    output logic        done,
    output logic [31:0] rotated_x,
    output logic [31:0] rotated_y,
    output logic [31:0] rotated_z,
    output logic        overflow,
    output logic        last_out,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rpa_pkg::cfg_t   cfg_reg;
    rpa_pkg::ctl_t   in_ctl;
    rpa_pkg::ctl_t   ctl_a;
    rpa_pkg::ctl_t   ctl_b;
    rpa_pkg::diff_t  diff [3];
    rpa_pkg::dot_t   dot;
    rpa_pkg::cross_t xprod [3];
    rpa_pkg::acc_t   acc [3];
    rpa_pkg::coord_t rot_x;
    rpa_pkg::coord_t rot_y;
    rpa_pkg::coord_t rot_z;

    // Every cycle can take an item
    assign busy         = 1'b0;
    assign in_ctl.valid = start & ~busy;
    assign in_ctl.last  = last_in;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x  <= '0;
            cfg_reg.center_y  <= '0;
            cfg_reg.center_z  <= '0;
            cfg_reg.axis_x    <= '0;
            cfg_reg.axis_y    <= '0;
            cfg_reg.axis_z    <= rpa_pkg::coef_t'(rpa_pkg::AXIS_Z_RESET);
            cfg_reg.cos_angle <= rpa_pkg::coef_t'(rpa_pkg::COS_RESET);
            cfg_reg.sin_angle <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rpa_pkg::REG_CENTER_X: cfg_reg.center_x  <= cfg_data;
                rpa_pkg::REG_CENTER_Y: cfg_reg.center_y  <= cfg_data;
                rpa_pkg::REG_CENTER_Z: cfg_reg.center_z  <= cfg_data;
                rpa_pkg::REG_AXIS_X:   cfg_reg.axis_x    <= cfg_data[rpa_pkg::COEF_W-1:0];
                rpa_pkg::REG_AXIS_Y:   cfg_reg.axis_y    <= cfg_data[rpa_pkg::COEF_W-1:0];
                rpa_pkg::REG_AXIS_Z:   cfg_reg.axis_z    <= cfg_data[rpa_pkg::COEF_W-1:0];
                rpa_pkg::REG_COS:      cfg_reg.cos_angle <= cfg_data[rpa_pkg::COEF_W-1:0];
                rpa_pkg::REG_SIN:      cfg_reg.sin_angle <= cfg_data[rpa_pkg::COEF_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Offset, dot and cross products
    rpa_proj u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (in_ctl),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .cfg     (cfg_reg),
        .out_ctl (ctl_a),
        .diff    (diff),
        .dot     (dot),
        .xprod   (xprod)
    );

    // Rodrigues terms and accumulation
    rpa_combine u_combine (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (ctl_a),
        .diff    (diff),
        .dot     (dot),
        .xprod   (xprod),
        .cfg     (cfg_reg),
        .out_ctl (ctl_b),
        .acc     (acc)
    );

    // Round, recenter, saturate
    rpa_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (ctl_b),
        .acc       (acc),
        .cfg       (cfg_reg),
        .done      (done),
        .rotated_x (rot_x),
        .rotated_y (rot_y),
        .rotated_z (rot_z),
        .overflow  (overflow),
        .last_out  (last_out)
    );

    assign rotated_x = rot_x;
    assign rotated_y = rot_y;
    assign rotated_z = rot_z;

endmodule
